/* rtl/xrg_pkg.sv */
package xrg_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int FRAC_W = 23;
  localparam int FRAC_SHIFT = 41;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_ONE  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_TWO  = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] RESET_A      = 64'd9223372036854775783;
  localparam logic [WORD_W-1:0] RESET_B      = 64'd6364136223846793005;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] seed_value;
  } xrg_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic [FRAC_W-1:0] unit_fraction;
  } xrg_rnd_t;

  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
  } xrg_seed_res_t;

endpackage

/* rtl/xrg_mul32.sv */
module xrg_mul32 (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);
  import xrg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
  end

endmodule

/* rtl/xrg_seeder.sv */
module xrg_seeder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            seed,
  output logic                   busy,
  output xrg_pkg::xrg_seed_res_t res
);
  import xrg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  logic [1:0]        state;
  logic [1:0]        cnt;
  logic              sel;
  logic              round;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] mconst;
  logic [WORD_W-1:0] fin;
  logic [WORD_W-1:0] acc_hi_sum;
  logic [HALF_W-1:0] op_a;
  logic [HALF_W-1:0] op_b;
  logic [WORD_W-1:0] prod;

  function automatic logic [WORD_W-1:0] premix(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] z;
    z = v + GOLDEN_GAMMA;
    return z ^ (z >> 30);
  endfunction

  xrg_mul32 u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign mconst     = sel ? MIX_MUL_TWO : MIX_MUL_ONE;
  assign fin        = acc ^ (acc >> 31);
  assign acc_hi_sum = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  always_comb begin
    unique case (cnt)
      2'd0: begin
        op_a = x[HALF_W-1:0];
        op_b = mconst[HALF_W-1:0];
      end
      2'd1: begin
        op_a = x[HALF_W-1:0];
        op_b = mconst[WORD_W-1:HALF_W];
      end
      2'd2: begin
        op_a = x[WORD_W-1:HALF_W];
        op_b = mconst[HALF_W-1:0];
      end
      default: begin
        op_a = x[HALF_W-1:0];
        op_b = mconst[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 2'd0;
      sel   <= 1'b0;
      round <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x     <= premix(seed);
            sel   <= 1'b0;
            round <= 1'b0;
            cnt   <= 2'd0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 2'd1;
          unique case (cnt)
            2'd1: acc <= prod;
            2'd2: acc <= acc_hi_sum;
            2'd3: begin
              acc   <= acc_hi_sum;
              state <= ST_POST;
            end
            default: ;
          endcase
        end
        ST_POST: begin
          cnt <= 2'd0;
          if (!sel) begin
            x     <= acc ^ (acc >> 27);
            sel   <= 1'b1;
            state <= ST_MUL;
          end else if (!round) begin
            word_a <= fin;
            x      <= premix(fin);
            round  <= 1'b1;
            sel    <= 1'b0;
            state  <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy       = (state != ST_IDLE);
  assign res.load   = (state == ST_POST) && sel && round;
  assign res.word_a = word_a;
  assign res.word_b = fin;

endmodule

/* rtl/xoroshiro_random_generator.sv */
// Channel | Signals                         | Payload
// cmd     | cmd_valid / cmd_ready           | cmd.action, cmd.seed_value
// rnd     | rnd_valid / rnd_ready           | rnd.random_word, rnd.unit_fraction
//
// A draw result is registered: it sits in an output register, so draws
// follow each other every cycle while rnd_ready stays high and no seed runs.
// A seed holds cmd_ready low after its beat: two finalizer rounds of two
// 64-bit multiplies, each stepped through one shared registered 32x32
// multiplier (three products) and then folded.
// cmd_ready is low while seeding and while an unread result is stalled.
// Reset (rst, synchronous) loads the fixed start state and empties the output.
module xoroshiro_random_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  xrg_pkg::xrg_cmd_t cmd,
  output logic              rnd_valid,
  input  logic              rnd_ready,
  output xrg_pkg::xrg_rnd_t rnd
);
  import xrg_pkg::*;

  logic [WORD_W-1:0] state_a;
  logic [WORD_W-1:0] state_b;
  logic [WORD_W-1:0] mix_t;
  logic [WORD_W-1:0] state_a_next;
  logic [WORD_W-1:0] state_b_next;
  logic [WORD_W-1:0] word;
  logic              cmd_fire;
  logic              seed_start;
  logic              draw_fire;
  logic              busy;
  xrg_seed_res_t     seed_res;

  xrg_seeder u_seeder (
    .clk   (clk),
    .rst   (rst),
    .start (seed_start),
    .seed  (cmd.seed_value),
    .busy  (busy),
    .res   (seed_res)
  );

  assign cmd_ready  = !busy && (!rnd_valid || rnd_ready);
  assign cmd_fire   = cmd_valid && cmd_ready;
  assign seed_start = cmd_fire && (cmd.action == ACT_SEED);
  assign draw_fire  = cmd_fire && (cmd.action == ACT_DRAW);

  assign mix_t        = state_a ^ state_b;
  assign state_a_next = {state_a[WORD_W-25:0], state_a[WORD_W-1:WORD_W-24]}
                        ^ mix_t ^ (mix_t << 16);
  assign state_b_next = {mix_t[WORD_W-38:0], mix_t[WORD_W-1:WORD_W-37]};
  assign word         = state_a_next + state_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_a   <= RESET_A;
      state_b   <= RESET_B;
      rnd_valid <= 1'b0;
    end else begin
      if (seed_res.load) begin
        state_a <= seed_res.word_a;
        state_b <= seed_res.word_b;
      end else if (draw_fire) begin
        state_a <= state_a_next;
        state_b <= state_b_next;
      end
      if (draw_fire) begin
        rnd_valid         <= 1'b1;
        rnd.random_word   <= word;
        rnd.unit_fraction <= word[FRAC_SHIFT +: FRAC_W];
      end else if (rnd_ready) begin
        rnd_valid <= 1'b0;
      end
    end
  end

  a_load_in_seed: assert property (@(posedge clk) disable iff (rst)
    seed_res.load |-> busy)
    else $error("seed load outside seeding");

  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    seed_start |=> busy)
    else $error("seed accepted but seeder idle");

  a_load_ends: assert property (@(posedge clk) disable iff (rst)
    seed_res.load |=> !busy)
    else $error("seeder still busy after load");

  a_draw_out: assert property (@(posedge clk) disable iff (rst)
    draw_fire |=> rnd_valid)
    else $error("draw gave no result");

endmodule
